// ===== rtl/core/albs_pkg.sv =====
`timescale 1ns / 1ps

package albs_pkg;

    // Field widths of one command beat
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    // Operation codes carried on the func field
    localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LINEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BINARY = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LIN  = 4'b0010,
        S_BRD  = 4'b0100,
        S_BCMP = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/albs_ram.sv =====
`timescale 1ns / 1ps

// Single write port, single read port, registered read data.
module albs_ram
    import albs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/array_linear_and_binary_search_core.sv =====
`timescale 1ns / 1ps

// Search table of TABLE_DEPTH signed 32-bit entries.
// Command channel: a beat is taken when start is high and busy is low.
//   func write      : stores value at write_address (ignored past the depth).
//   func linear     : scans [low_index, high_index] for value.
//   func binary     : binary search of [low_index, high_index], assumed sorted.
//   high_index past the depth is clamped to the last entry; low above high
//   gives not found.
// Result channel: o_strobe high for exactly one cycle with o_found; the
// receiver cannot hold it off, so every command beat yields one result beat.
// Per command:
//   write / unused code : not found in the next cycle; busy stays low, so these
//                         may come every cycle.
//   linear              : stops at the first hit. One table read a cycle,
//                         pipelined against the compare of the previous read.
//   binary              : each probe is a read in S_BRD, then a compare in
//                         S_BCMP of the registered read data.
// Reset clears the sequencer and the strobe; table contents are not cleared
// and an entry must be written before it is searched.
module array_linear_and_binary_search_core
    import albs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [IDX_W-1:0]         i_write_address,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_low_index,
    input  logic [IDX_W-1:0]         i_high_index,
    output logic                     o_strobe,
    output logic                     o_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // signed working width: holds -1 and one past the last index
    localparam int XW = (AW > IDX_W) ? AW + 2 : IDX_W + 2;
    localparam logic signed [XW-1:0] LAST_IDX = XW'(TABLE_DEPTH - 1);
    localparam logic signed [XW-1:0] ONE_X    = XW'(1);

    t_state                   r_state, n_state;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [XW-1:0]     r_lo, n_lo;
    logic signed [XW-1:0]     r_hi, n_hi;
    logic signed [XW-1:0]     r_mid, n_mid;
    logic                     r_more, n_more;   // linear: entries left to read
    logic                     r_chk, n_chk;     // linear: read data due this cycle
    logic                     r_strobe, n_strobe;
    logic                     r_found, n_found;

    logic                     w_accept;
    logic signed [XW-1:0]     w_lo_x, w_hi_x, w_hi_sat, w_addr_x;
    logic signed [XW-1:0]     w_mid;
    logic                     w_empty;
    logic                     w_we;
    logic                     w_re;
    logic [AW-1:0]            w_raddr;
    logic [DATA_W-1:0]        w_rdata_raw;
    logic signed [DATA_W-1:0] w_rdata;
    logic                     w_hit, w_gt;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_lo_x   = $signed({{(XW-IDX_W){1'b0}}, i_low_index});
    assign w_hi_x   = $signed({{(XW-IDX_W){1'b0}}, i_high_index});
    assign w_addr_x = $signed({{(XW-IDX_W){1'b0}}, i_write_address});
    assign w_hi_sat = (w_hi_x > LAST_IDX) ? LAST_IDX : w_hi_x;

    // writes beyond the table are dropped
    assign w_we = w_accept && (i_func == FN_WRITE) && (w_addr_x <= LAST_IDX);

    // binary probe point: lo + (hi - lo + 1) / 2, range known non-empty
    assign w_mid   = r_lo + ((r_hi - r_lo + ONE_X) >>> 1);
    assign w_empty = (r_hi < r_lo);

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_lo[AW-1:0];
        case (r_state)
            S_LIN: begin
                w_re    = r_more;
                w_raddr = r_lo[AW-1:0];
            end
            S_BRD: begin
                w_re    = !w_empty;
                w_raddr = w_mid[AW-1:0];
            end
            default: begin
                w_re    = 1'b0;
                w_raddr = r_lo[AW-1:0];
            end
        endcase
    end

    albs_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr_x[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = $signed(w_rdata_raw);
    assign w_hit   = (w_rdata == r_key);
    assign w_gt    = (w_rdata > r_key);

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_more   = r_more;
        n_chk    = r_chk;
        n_strobe = 1'b0;
        n_found  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key = i_value;
                    n_lo  = w_lo_x;
                    n_hi  = w_hi_sat;
                    n_chk = 1'b0;
                    case (i_func)
                        FN_LINEAR: begin
                            n_state = S_LIN;
                            n_more  = (w_lo_x <= w_hi_sat);
                        end
                        FN_BINARY: begin
                            n_state = S_BRD;
                        end
                        default: begin
                            // write or unused code: answer not found at once
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_LIN: begin
                // read of r_lo goes out while the previous beat is compared
                n_chk = r_more;
                if (r_more) begin
                    n_lo   = r_lo + ONE_X;
                    n_more = (r_lo != r_hi);
                end
                if (r_chk && w_hit) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_state  = S_IDLE;
                end else if (!r_more && !r_chk) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_BRD: begin
                if (w_empty) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_mid   = w_mid;
                    n_state = S_BCMP;
                end
            end
            S_BCMP: begin
                if (w_hit) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (w_gt) begin
                        n_hi = r_mid - ONE_X;
                    end else begin
                        n_lo = r_mid + ONE_X;
                    end
                    n_state = S_BRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_more   <= 1'b0;
            r_chk    <= 1'b0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_more   <= n_more;
            r_chk    <= n_chk;
            r_strobe <= n_strobe;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

    assign o_strobe = r_strobe;
    assign o_found  = r_found;

endmodule

// ===== rtl/core/albs_checker.sv =====
`timescale 1ns / 1ps

module albs_checker
    import albs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [FUNC_W-1:0]        i_func,
    input logic                     o_strobe,
    input logic                     o_found
);

    logic w_accept;
    logic w_search;

    assign w_accept = start && !busy;
    assign w_search = (i_func == FN_LINEAR) || (i_func == FN_BINARY);

    // reset leaves no result beat behind
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result beat straight after reset");

    // a result beat only comes out once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    // writes and unused codes answer not found on the next cycle
    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_search) |=> (o_strobe && !o_found && !busy))
        else $error("write beat not answered next cycle");

    // a search holds the block busy and gives no result on the next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_search) |=> (busy && !o_strobe))
        else $error("search beat did not occupy the block");

endmodule

bind array_linear_and_binary_search_core albs_checker u_albs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_func   (i_func),
    .o_strobe (o_strobe),
    .o_found  (o_found)
);
